// File: hw/rtl/mpc_pkg.sv
// ----------------------------------------------------------------------------
// mpc_pkg - shared types and constants of the perceptron classifier
// field widths, config register indexes, datapath opcodes and status bundle
// ----------------------------------------------------------------------------
package mpc_pkg;

  localparam int FEAT_W = 16;
  localparam int WGT_W  = 32;
  localparam int PROD_W = 48;
  localparam int SUM_W  = 48;
  localparam int LR_W   = 16;
  localparam int CC_W   = 5;
  localparam int AC_W   = 4;
  localparam int LBL_W  = 4;
  localparam int PC_W   = 4;
  localparam int STEPM_W = 33;
  localparam int DELTA_W = 25;

  localparam int CFG_AW = 2;
  localparam int CFG_DW = 16;

  localparam logic [CFG_AW-1:0] REG_LEARNING_RATE = 2'd0;
  localparam logic [CFG_AW-1:0] REG_CLASS_COUNT   = 2'd1;
  localparam logic [CFG_AW-1:0] REG_ACTIVE_CLASS  = 2'd2;

  localparam logic [LR_W-1:0] LR_RESET = 16'd655;
  localparam logic [CC_W-1:0] CC_RESET = 5'd2;
  localparam logic [AC_W-1:0] AC_RESET = 4'd0;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_CAPTURE,
    OP_MUL,
    OP_ACC,
    OP_AM_INIT,
    OP_AM_STEP,
    OP_UPD_INIT,
    OP_UPD_MUL,
    OP_UPD_RND,
    OP_UPD_WR,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic rd_sweep;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic am_done;
    logic upd_needed;
    logic upd_last;
    logic out_free;
    logic last_beat;
  } stat_t;

  // add a product (Q24.24) floored to Q24.16 into a saturating 48-bit sum
  function automatic logic signed [SUM_W-1:0] sum_sat(input logic signed [SUM_W-1:0] s,
                                                      input logic signed [PROD_W-1:0] p);
    logic signed [SUM_W:0] t;
    t = {s[SUM_W-1], s} + {{9{p[PROD_W-1]}}, p[PROD_W-1:8]};
    if (t[SUM_W] != t[SUM_W-1]) begin
      sum_sat = t[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_sat = t[SUM_W-1:0];
    end
  endfunction

endpackage

// File: hw/rtl/mpc_in_if.sv
// ----------------------------------------------------------------------------
// mpc_in_if - feature stream channel
// one feature of a sample per beat, with mode, label and end marker
// ----------------------------------------------------------------------------
interface mpc_in_if import mpc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              func;
  logic [FEAT_W-1:0] feature;
  logic [LBL_W-1:0]  label;
  logic              last;

  modport source (output valid, output func, output feature, output label, output last,
                  input ready);
  modport sink   (input valid, input func, input feature, input label, input last,
                  output ready);
endinterface

// File: hw/rtl/mpc_out_if.sv
// ----------------------------------------------------------------------------
// mpc_out_if - classification result channel
// one beat per sample: predicted class and training flags
// ----------------------------------------------------------------------------
interface mpc_out_if import mpc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PC_W-1:0] pred_class;
  logic            updated;
  logic            weight_saturated;

  modport source (output valid, output pred_class, output updated,
                  output weight_saturated, input ready);
  modport sink   (input valid, input pred_class, input updated,
                  input weight_saturated, output ready);
endinterface

// File: hw/rtl/mpc_datapath.sv
// ----------------------------------------------------------------------------
// mpc_datapath - weight lanes, sample buffer, argmax and update arithmetic
// one weight memory and one mac per class, driven by controller opcodes
// ----------------------------------------------------------------------------
module mpc_datapath import mpc_pkg::*; #(
  parameter int MAX_FEATURES = 64,
  parameter int MAX_CLASSES  = 16,
  parameter int NW           = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output stat_t             stat,
  input  logic              func_i,
  input  logic [FEAT_W-1:0] feature_i,
  input  logic [LBL_W-1:0]  label_i,
  input  logic              last_i,
  input  logic [LR_W-1:0]   learning_rate,
  input  logic [NW-1:0]     class_n,
  input  logic [AC_W-1:0]   active_class,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [PC_W-1:0]   out_class,
  output logic              out_updated,
  output logic              out_saturated
);

  localparam int FAW  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int IW   = $clog2(MAX_FEATURES + 1);
  localparam int CW   = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int SPAN = (MAX_FEATURES > MAX_CLASSES) ? MAX_FEATURES : MAX_CLASSES;
  localparam int SW   = $clog2(SPAN + 1);

  logic [IW-1:0]               feat_idx_r;
  logic [SW-1:0]               sweep_r;
  logic signed [FEAT_W-1:0]    x_r;
  logic                        func_r;
  logic [LBL_W-1:0]            label_r;
  logic                        last_r;
  logic [CW-1:0]               best_r;
  logic signed [SUM_W-1:0]     best_sum_r;
  logic                        upd_r;
  logic                        sat_r;
  logic signed [STEPM_W-1:0]   m_r;
  logic signed [DELTA_W-1:0]   d_r;
  logic                        out_valid_r;
  logic [PC_W-1:0]             out_class_r;
  logic                        out_upd_r;
  logic                        out_sat_r;
  logic signed [FEAT_W-1:0]    buf_rd_r;

  logic signed [FEAT_W-1:0]    sbuf [MAX_FEATURES];
  logic signed [WGT_W-1:0]     wrd  [MAX_CLASSES];
  logic signed [PROD_W-1:0]    prod_r [MAX_CLASSES];
  logic signed [SUM_W-1:0]     sums_r [MAX_CLASSES];

  logic [FAW-1:0]              rd_addr;
  logic [FAW-1:0]              wr_addr;
  logic                        in_range;
  logic [CW-1:0]               act_idx;
  logic signed [SUM_W-1:0]     cur_sum;
  logic                        want;
  logic                        got;
  logic signed [WGT_W-1:0]     w_act;
  logic [STEPM_W-1:0]          mag;
  logic [STEPM_W-1:0]          rnd;
  logic [DELTA_W-1:0]          dmag;
  logic                        neg;
  logic signed [WGT_W:0]       wsum;
  logic                        wovf;
  logic signed [WGT_W-1:0]     wnew;
  logic signed [WGT_W-1:0]     wr_data;

  assign rd_addr  = cmd.rd_sweep ? sweep_r[FAW-1:0] : feat_idx_r[FAW-1:0];
  assign wr_addr  = sweep_r[FAW-1:0];
  assign in_range = feat_idx_r < IW'(MAX_FEATURES);
  assign act_idx  = CW'(active_class);
  assign cur_sum  = sums_r[sweep_r[CW-1:0]];
  assign want     = 32'(label_r) == 32'(active_class);
  assign got      = 32'(best_r) == 32'(active_class);
  assign w_act    = wrd[act_idx];

  // step magnitude rounded half away from zero, then signed by direction
  assign mag  = m_r[STEPM_W-1] ? STEPM_W'(-m_r) : STEPM_W'(m_r);
  assign rnd  = mag + STEPM_W'(128);
  assign dmag = rnd[STEPM_W-1:8];
  assign neg  = m_r[STEPM_W-1] ^ ~want;

  assign wsum = {w_act[WGT_W-1], w_act} + {{(WGT_W+1-DELTA_W){d_r[DELTA_W-1]}}, d_r};
  assign wovf = wsum[WGT_W] != wsum[WGT_W-1];
  assign wnew = wovf ? (wsum[WGT_W] ? {1'b1, {(WGT_W-1){1'b0}}} : {1'b0, {(WGT_W-1){1'b1}}})
                     : wsum[WGT_W-1:0];
  assign wr_data = (cmd.op == OP_CLEAR) ? '0 : wnew;

  // per-class lanes: weight memory, product register, running sum
  for (genvar c = 0; c < MAX_CLASSES; c++) begin : g_lane
    logic signed [WGT_W-1:0] wmem [MAX_FEATURES];
    logic                    we;

    assign we = (cmd.op == OP_CLEAR) || (cmd.op == OP_UPD_WR && act_idx == CW'(c));

    always_ff @(posedge clk) begin
      if (we) begin
        wmem[wr_addr] <= wr_data;
      end
      wrd[c] <= wmem[rd_addr];
      if (cmd.op == OP_MUL) begin
        prod_r[c] <= PROD_W'(x_r) * PROD_W'(wrd[c]);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sums_r[c] <= '0;
      end else if (cmd.op == OP_OUT) begin
        sums_r[c] <= '0;
      end else if (cmd.op == OP_ACC && in_range) begin
        sums_r[c] <= sum_sat(sums_r[c], prod_r[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_CAPTURE && in_range) begin
      sbuf[feat_idx_r[FAW-1:0]] <= feature_i;
    end
    buf_rd_r <= sbuf[rd_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      feat_idx_r  <= '0;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
      upd_r       <= 1'b0;
      sat_r       <= 1'b0;
      last_r      <= 1'b0;
      func_r      <= 1'b0;
    end else begin
      if (cmd.op == OP_OUT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (cmd.op)
        OP_CLEAR:    sweep_r <= sweep_r + SW'(1);
        OP_CAPTURE: begin
          func_r <= func_i;
          last_r <= last_i;
        end
        OP_ACC: begin
          if (in_range) begin
            feat_idx_r <= feat_idx_r + IW'(1);
          end
        end
        OP_AM_INIT: begin
          sweep_r <= SW'(1);
          upd_r   <= 1'b0;
          sat_r   <= 1'b0;
        end
        OP_AM_STEP:  sweep_r <= sweep_r + SW'(1);
        OP_UPD_INIT: begin
          sweep_r <= '0;
          upd_r   <= 1'b1;
        end
        OP_UPD_WR: begin
          sweep_r <= sweep_r + SW'(1);
          sat_r   <= sat_r | wovf;
        end
        OP_OUT:      feat_idx_r <= '0;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_CAPTURE: begin
        x_r     <= feature_i;
        label_r <= label_i;
      end
      OP_AM_INIT: begin
        best_r     <= '0;
        best_sum_r <= sums_r[0];
      end
      OP_AM_STEP: begin
        if (cur_sum > best_sum_r) begin
          best_r     <= sweep_r[CW-1:0];
          best_sum_r <= cur_sum;
        end
      end
      OP_UPD_MUL: m_r <= $signed({1'b0, learning_rate}) * buf_rd_r;
      OP_UPD_RND: d_r <= neg ? DELTA_W'(-$signed({1'b0, dmag})) : DELTA_W'(dmag);
      OP_OUT: begin
        out_class_r <= PC_W'(best_r);
        out_upd_r   <= upd_r;
        out_sat_r   <= sat_r;
      end
      default: ;
    endcase
  end

  assign stat.clr_last   = 32'(sweep_r) == MAX_FEATURES - 1;
  assign stat.am_done    = 32'(sweep_r) >= 32'(class_n);
  assign stat.upd_needed = func_r && (32'(active_class) < 32'(class_n)) && (want != got);
  assign stat.upd_last   = 32'(sweep_r) + 1 == 32'(feat_idx_r);
  assign stat.out_free   = !out_valid_r || out_ready;
  assign stat.last_beat  = last_r;

  assign out_valid     = out_valid_r;
  assign out_class     = out_class_r;
  assign out_updated   = out_upd_r;
  assign out_saturated = out_sat_r;

endmodule

// File: hw/rtl/mpc_ctrl.sv
// ----------------------------------------------------------------------------
// mpc_ctrl - sequencer of the perceptron classifier
// walks clear, mac, argmax, update and output phases, issuing opcodes
// ----------------------------------------------------------------------------
module mpc_ctrl import mpc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_ACC,
    S_AM_INIT,
    S_AM,
    S_UPD_INIT,
    S_UPD_RD,
    S_UPD_MUL,
    S_UPD_RND,
    S_UPD_WR,
    S_OUT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt    = state_r;
    cmd.op       = OP_NONE;
    cmd.rd_sweep = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_CAPTURE;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.op    = OP_MUL;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.op    = OP_ACC;
        state_nxt = stat.last_beat ? S_AM_INIT : S_IDLE;
      end
      S_AM_INIT: begin
        cmd.op    = OP_AM_INIT;
        state_nxt = S_AM;
      end
      S_AM: begin
        if (!stat.am_done) begin
          cmd.op = OP_AM_STEP;
        end else begin
          state_nxt = stat.upd_needed ? S_UPD_INIT : S_OUT;
        end
      end
      S_UPD_INIT: begin
        cmd.op    = OP_UPD_INIT;
        state_nxt = S_UPD_RD;
      end
      S_UPD_RD: begin
        cmd.rd_sweep = 1'b1;
        state_nxt    = S_UPD_MUL;
      end
      S_UPD_MUL: begin
        cmd.op       = OP_UPD_MUL;
        cmd.rd_sweep = 1'b1;
        state_nxt    = S_UPD_RND;
      end
      S_UPD_RND: begin
        cmd.op       = OP_UPD_RND;
        cmd.rd_sweep = 1'b1;
        state_nxt    = S_UPD_WR;
      end
      S_UPD_WR: begin
        cmd.op       = OP_UPD_WR;
        cmd.rd_sweep = 1'b1;
        state_nxt    = stat.upd_last ? S_OUT : S_UPD_RD;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.op    = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

// File: hw/rtl/multiclass_perceptron_classifier_unit.sv
// ----------------------------------------------------------------------------
// multiclass_perceptron_classifier_unit - one-vs-rest perceptron, fixed point
// streams features, predicts the argmax class and trains one class's weights
// ----------------------------------------------------------------------------
//  channel | dir | handshake        | payload
//  in_bus  | in  | valid / ready    | func, feature (Q8.8), label, last
//  out_bus | out | valid / ready    | pred_class, updated, weight_saturated
//  cfg_*   | in  | cfg_we, no ready | cfg_addr selects register, cfg_wdata
//
//  a feature beat steps through capture and weight read, per-class multiply,
//  per-class accumulate (all class lanes in parallel)
//  a last beat then runs argmax (init, one compare per further class in use,
//  decision), then, when a training update is made, an init step and a read,
//  multiply, round and write step per buffered feature, then loads the result
//  register; the next sample may start while the result waits there
//  after reset a clearing pass zeroes the weights, one row across all class
//  lanes per cycle, with in_bus.ready low
//  a stalled result holds in the output register and blocks only the next
//  last beat
// ----------------------------------------------------------------------------
module multiclass_perceptron_classifier_unit import mpc_pkg::*; #(
  parameter int MAX_FEATURES = 64,
  parameter int MAX_CLASSES  = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  mpc_in_if.sink            in_bus,
  mpc_out_if.source         out_bus,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  localparam int NW = $clog2(MAX_CLASSES + 1);

  // configuration registers
  logic [LR_W-1:0] learning_rate_r;
  logic [CC_W-1:0] class_count_r;
  logic [AC_W-1:0] active_class_r;
  logic [NW-1:0]   class_n;

  cmd_t  cmd;
  stat_t stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      learning_rate_r <= LR_RESET;
      class_count_r   <= CC_RESET;
      active_class_r  <= AC_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_LEARNING_RATE: learning_rate_r <= cfg_wdata[LR_W-1:0];
        REG_CLASS_COUNT:   class_count_r   <= cfg_wdata[CC_W-1:0];
        REG_ACTIVE_CLASS:  active_class_r  <= cfg_wdata[AC_W-1:0];
        default: ;
      endcase
    end
  end

  // classes in use: zero counts as one, clamp at the lane count
  always_comb begin
    priority if (class_count_r == '0) begin
      class_n = NW'(1);
    end else if (32'(class_count_r) > MAX_CLASSES) begin
      class_n = NW'(MAX_CLASSES);
    end else begin
      class_n = NW'(class_count_r);
    end
  end

  mpc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mpc_datapath #(
    .MAX_FEATURES (MAX_FEATURES),
    .MAX_CLASSES  (MAX_CLASSES),
    .NW           (NW)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .func_i        (in_bus.func),
    .feature_i     (in_bus.feature),
    .label_i       (in_bus.label),
    .last_i        (in_bus.last),
    .learning_rate (learning_rate_r),
    .class_n       (class_n),
    .active_class  (active_class_r),
    .out_ready     (out_bus.ready),
    .out_valid     (out_bus.valid),
    .out_class     (out_bus.pred_class),
    .out_updated   (out_bus.updated),
    .out_saturated (out_bus.weight_saturated)
  );

  // a clamp only happens during an update
  a_sat_needs_upd: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid |-> (out_bus.updated || !out_bus.weight_saturated))
    else $error("saturation flagged without update");

  // one beat at a time: no accept in the cycle after an accept
  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_bus.valid && in_bus.ready) |=> !in_bus.ready)
    else $error("back to back accept");

  // a new result only loads when the output register is free
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_OUT) |-> (!out_bus.valid || out_bus.ready))
    else $error("result overwritten");

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench - perceptron classifier unit check
// streams predict and train samples with random gaps, predicts every result
// beat from an in-bench fixed point model and compares field by field
// ----------------------------------------------------------------------------
module testbench;
  import mpc_pkg::*;

  localparam int NF = 64;
  localparam int NC = 16;

  typedef struct packed {
    logic [PC_W-1:0] cls;
    logic            upd;
    logic            sat;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  mpc_in_if  in_bus ();
  mpc_out_if out_bus ();

  multiclass_perceptron_classifier_unit dut (
    .clk(clk), .rst_n(rst_n), .in_bus(in_bus.sink), .out_bus(out_bus.source),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // model state
  logic signed [WGT_W-1:0]  wgt [NC*NF];
  logic signed [FEAT_W-1:0] buffered [NF];
  logic signed [SUM_W-1:0]  sums [NC];
  int unsigned              fidx;
  logic [LR_W-1:0] m_rate;
  logic [CC_W-1:0] m_count;
  logic [AC_W-1:0] m_active;

  verdict_t pending [$];
  int       errors = 0;
  bit       sink_stall_on = 1'b1;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  function automatic int unsigned used_classes();
    int unsigned n;
    n = m_count;
    if (n == 0) n = 1;
    if (n > NC) n = NC;
    return n;
  endfunction

  // one beat into the model; pushes a verdict on a last beat
  task automatic classify_beat(input logic fn, input logic signed [FEAT_W-1:0] x,
                               input logic [LBL_W-1:0] lbl, input logic lst);
    int unsigned n, best;
    logic signed [63:0] p, s, m, mag, d, w;
    logic want, got;
    verdict_t v;
    n = used_classes();
    if (fidx < NF) begin
      buffered[fidx] = x;
      for (int c = 0; c < n; c++) begin
        p = 64'(x) * 64'(wgt[c*NF+fidx]);
        s = 64'(sums[c]) + (p >>> 8);
        if (s > 64'sh7FFF_FFFF_FFFF) s = 64'sh7FFF_FFFF_FFFF;
        if (s < -64'sh8000_0000_0000) s = -64'sh8000_0000_0000;
        sums[c] = s[SUM_W-1:0];
      end
      fidx++;
    end
    if (!lst) return;
    best = 0;
    for (int c = 1; c < n; c++) if (sums[c] > sums[best]) best = c;
    v = '{cls: best[PC_W-1:0], upd: 1'b0, sat: 1'b0};
    if (fn && m_active < n) begin
      want = (lbl == m_active);
      got = (best == m_active);
      if (want != got) begin
        v.upd = 1'b1;
        for (int j = 0; j < fidx; j++) begin
          m = 64'(signed'({1'b0, m_rate})) * 64'(buffered[j]);
          mag = m < 0 ? -m : m;
          d = (mag + 128) >>> 8;
          if ((m < 0) != !want) d = -d;
          w = 64'(wgt[m_active*NF+j]) + d;
          if (w > 64'sh7FFF_FFFF) begin w = 64'sh7FFF_FFFF; v.sat = 1'b1; end
          if (w < -64'sh8000_0000) begin w = -64'sh8000_0000; v.sat = 1'b1; end
          wgt[m_active*NF+j] = w[WGT_W-1:0];
        end
      end
    end
    pending.push_back(v);
    for (int c = 0; c < NC; c++) sums[c] = '0;
    fidx = 0;
  endtask

  function automatic int gap_len();
    if ($urandom_range(0, 3) != 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  // send one beat; valid stays high across back-to-back beats
  task automatic send_beat(input logic fn, input logic [FEAT_W-1:0] x,
                           input logic [LBL_W-1:0] lbl, input logic lst);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_bus.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.func    <= fn;
    in_bus.feature <= x;
    in_bus.label   <= lbl;
    in_bus.last    <= lst;
    do @(posedge clk); while (!in_bus.ready);
    classify_beat(fn, x, lbl, lst);
  endtask

  task automatic go_idle();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending.size() != 0) @(posedge clk);
    // every result has been taken, so no train update is still walking the buffer
    repeat (NC + 4 * NF + 20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_LEARNING_RATE) m_rate = val;
    else if (idx == REG_CLASS_COUNT) m_count = val[CC_W-1:0];
    else if (idx == REG_ACTIVE_CLASS) m_active = val[AC_W-1:0];
  endtask

  function automatic logic [FEAT_W-1:0] rand_feature();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic send_sample(input logic fn, input int len, input logic [LBL_W-1:0] lbl);
    for (int i = 0; i < len; i++)
      send_beat(fn, rand_feature(), lbl, i == len - 1);
  endtask

  // extremes of every field, both modes, overlong sample
  task automatic test_directed();
    send_beat(1'b0, 16'h7FFF, 4'd0, 1'b1);
    send_beat(1'b1, 16'h7FFF, 4'd1, 1'b1);
    send_beat(1'b1, 16'h8000, 4'd0, 1'b0);
    send_beat(1'b1, 16'h7FFF, 4'd15, 1'b1);
    send_sample(1'b1, 3, 4'd0);
    send_sample(1'b0, 3, 4'd5);
    send_sample(1'b1, NF + 3, 4'd1);  // features past the buffer are dropped
    send_beat(1'b0, 16'h0100, 4'd0, 1'b1);
    go_idle();
  endtask

  // class count zero, above max, maximum; active class out of use
  task automatic test_class_count();
    write_reg(REG_CLASS_COUNT, 16'd0);
    send_sample(1'b1, 2, 4'd3);
    go_idle();
    write_reg(REG_CLASS_COUNT, 16'd31);
    write_reg(REG_ACTIVE_CLASS, 16'd15);
    send_sample(1'b1, 2, 4'd15);
    send_sample(1'b1, 2, 4'd2);
    go_idle();
    write_reg(REG_CLASS_COUNT, 16'd4);
    write_reg(REG_ACTIVE_CLASS, 16'd9);
    send_sample(1'b1, 2, 4'd9);
    go_idle();
  endtask

  // weights driven into saturation with the largest rate: a lone class always
  // predicts itself, so a foreign label keeps stepping its weight down
  task automatic test_saturation();
    write_reg(REG_LEARNING_RATE, 16'hFFFF);
    write_reg(REG_CLASS_COUNT, 16'd1);
    write_reg(REG_ACTIVE_CLASS, 16'd0);
    for (int k = 0; k < 264; k++) send_beat(1'b1, 16'h7FFF, 4'd1, 1'b1);
    go_idle();
    write_reg(REG_CLASS_COUNT, 16'd2);
    write_reg(REG_LEARNING_RATE, 16'd0);
    send_sample(1'b1, 4, 4'd0);
    go_idle();
  endtask

  // random phases with varied settings, mostly short training samples
  task automatic test_random();
    int beats, len, nc;
    beats = 0;
    for (int ph = 0; beats < 1450; ph++) begin
      nc = $urandom_range(1, 16);
      write_reg(REG_LEARNING_RATE, 16'($urandom()));
      write_reg(REG_CLASS_COUNT, 16'(nc));
      write_reg(REG_ACTIVE_CLASS, 16'($urandom_range(0, nc - 1)));
      sink_stall_on = (ph % 3 != 2);
      for (int s = 0; s < 25; s++) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(NF - 2, NF + 2)
                                           : $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
          send_beat($urandom_range(0, 3) != 0, rand_feature(),
                    ($urandom_range(0, 1) ? m_active : 4'($urandom())), i == len - 1);
        beats += len;
      end
      go_idle();
    end
  endtask

  // result side: random stalls and the check against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (pending.size() == 0) begin
          report("unexpected beat", 32'd0, 32'd0);
        end else begin
          verdict_t v;
          v = pending.pop_front();
          if (out_bus.pred_class !== v.cls)
            report("pred_class", 32'(out_bus.pred_class), 32'(v.cls));
          if (out_bus.updated !== v.upd)
            report("updated", 32'(out_bus.updated), 32'(v.upd));
          if (out_bus.weight_saturated !== v.sat)
            report("weight_saturated", 32'(out_bus.weight_saturated), 32'(v.sat));
        end
      end
      out_bus.ready <= !sink_stall_on || ($urandom_range(0, 9) < 7) ||
                       ($urandom_range(0, 30) == 0);
    end
  end

  initial begin
    in_bus.valid = 1'b0;
    in_bus.func = 1'b0;
    in_bus.feature = '0;
    in_bus.label = '0;
    in_bus.last = 1'b0;
    out_bus.ready = 1'b0;
    for (int i = 0; i < NC*NF; i++) wgt[i] = '0;
    for (int i = 0; i < NF; i++) buffered[i] = '0;
    for (int c = 0; c < NC; c++) sums[c] = '0;
    fidx = 0;
    m_rate = LR_RESET;
    m_count = CC_RESET;
    m_active = AC_RESET;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    write_reg(REG_LEARNING_RATE, 16'd4096);
    write_reg(REG_CLASS_COUNT, 16'd16);
    write_reg(REG_ACTIVE_CLASS, 16'd0);
    test_class_count();
    test_saturation();
    test_random();
    if (errors == 0) begin
      $display("PASS multiclass_perceptron_classifier_unit");
    end else begin
      $display("FAIL multiclass_perceptron_classifier_unit");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("FAIL multiclass_perceptron_classifier_unit");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/mpc_pkg.sv
hw/rtl/mpc_in_if.sv
hw/rtl/mpc_out_if.sv
hw/rtl/mpc_datapath.sv
hw/rtl/mpc_ctrl.sv
hw/rtl/multiclass_perceptron_classifier_unit.sv
tb/testbench.sv
